### rtl/two_way_traffic_light_sequencer_macros.svh
// Assertion macros for the two-way traffic light sequencer.
`ifndef TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH
`define TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define TLSEQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tlseq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define TLSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tlseq: next-cycle check failed");

`else

`define TLSEQ_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TLSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/tlseq_pkg.sv
// Shared types and constants of the traffic light sequencer.
`timescale 1ns / 1ps

package tlseq_pkg;

    // Lamp coding on the result ports
    typedef enum logic [1:0] {
        LAMP_OFF    = 2'd0,
        LAMP_RED    = 2'd1,
        LAMP_YELLOW = 2'd2,
        LAMP_GREEN  = 2'd3
    } lamp_t;

    // Sequence mode
    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_AUTO       = 2'd1,
        MODE_MAN_YELLOW = 2'd2,
        MODE_MAN_GREEN  = 2'd3
    } mode_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int COUNT_W    = 7;
    localparam int YLEN_W     = 4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CHANGE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_CHANGE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THIRD_CHANGE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CYCLE         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAN_YELLOW    = 3'd4;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_FIRST_CHANGE  = 7'd3;
    localparam logic [COUNT_W-1:0] RST_SECOND_CHANGE = 7'd23;
    localparam logic [COUNT_W-1:0] RST_THIRD_CHANGE  = 7'd26;
    localparam logic [COUNT_W-1:0] RST_CYCLE         = 7'd38;
    localparam logic [YLEN_W-1:0]  RST_MAN_YELLOW    = 4'd3;

    // Limits applied to the lengths
    localparam logic [COUNT_W-1:0] CYCLE_MAX  = 7'd99;
    localparam logic [YLEN_W-1:0]  YELLOW_MAX = 4'd9;

    typedef struct packed {
        logic [COUNT_W-1:0] first_change;
        logic [COUNT_W-1:0] second_change;
        logic [COUNT_W-1:0] third_change;
        logic [COUNT_W-1:0] cycle_len;
        logic [YLEN_W-1:0]  yellow_len;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
        logic               dir;
        lamp_t              south;
        lamp_t              west;
    } seq_state_t;

    typedef struct packed {
        lamp_t      south;
        lamp_t      west;
        logic [3:0] tens;
        logic [3:0] ones;
    } result_t;

endpackage

### rtl/two_way_traffic_light_sequencer.sv
// Top level of the two-way traffic light sequencer.
// Each request is one one-second tick carrying the mode and direction switch
// levels; each produces exactly one result with both lamps and a two-digit
// BCD count. A request is accepted in any cycle where the result register is
// empty or is being drained, so the block sustains one request per clock;
// the result appears in the result register in the cycle after acceptance. The
// sequence step is combinational logic between the state register and the
// result register. Configuration writes take effect on the next clock.
`timescale 1ns / 1ps
`include "two_way_traffic_light_sequencer_macros.svh"

module two_way_traffic_light_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tlseq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tlseq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_auto_switch,
    input  logic                              s_direction_switch,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_south_lamp,
    output logic [1:0]                        m_west_lamp,
    output logic [3:0]                        m_display_tens,
    output logic [3:0]                        m_display_ones
);
    import tlseq_pkg::*;

    cfg_t       cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t step_nxt;
    result_t    step_res;
    result_t    res_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       in_accept;

    tlseq_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    tlseq_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .auto_sw (s_auto_switch),
        .dir_sw  (s_direction_switch),
        .nxt     (step_nxt),
        .res     (step_res)
    );

    // Accept while the result register is free or draining
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Next sequence state and result valid
    always_comb begin
        state_next   = in_accept ? step_nxt : state_reg;
        m_valid_next = in_accept ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= MODE_IDLE;
            state_reg.count <= '0;
            state_reg.dir   <= 1'b0;
            state_reg.south <= LAMP_OFF;
            state_reg.west  <= LAMP_OFF;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded on each accepted request
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_reg <= step_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_south_lamp   = res_reg.south;
    assign m_west_lamp    = res_reg.west;
    assign m_display_tens = res_reg.tens;
    assign m_display_ones = res_reg.ones;

    // Checks
    `TLSEQ_ASSERT_IMPL(a_bcd_digits, aclk, aresetn, m_valid_reg, (res_reg.tens <= 4'd9) && (res_reg.ones <= 4'd9))
    `TLSEQ_ASSERT_IMPL(a_green_count, aclk, aresetn, state_reg.mode == MODE_MAN_GREEN, state_reg.count == '0)
    `TLSEQ_ASSERT_IMPL(a_auto_count, aclk, aresetn, state_reg.mode == MODE_AUTO, (state_reg.count != '0) && (state_reg.count <= CYCLE_MAX))
    `TLSEQ_ASSERT_NEXT(a_auto_entry, aclk, aresetn, in_accept && s_auto_switch, m_valid_reg && (state_reg.mode == MODE_AUTO))

endmodule

### rtl/tlseq_cfg.sv
// Configuration register bank of the traffic light sequencer.
`timescale 1ns / 1ps

module tlseq_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tlseq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tlseq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output tlseq_pkg::cfg_t                   cfg
);
    import tlseq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FIRST_CHANGE:  cfg_next.first_change  = cfg_wr_data;
                CFG_SECOND_CHANGE: cfg_next.second_change = cfg_wr_data;
                CFG_THIRD_CHANGE:  cfg_next.third_change  = cfg_wr_data;
                CFG_CYCLE:         cfg_next.cycle_len     = cfg_wr_data;
                CFG_MAN_YELLOW:    cfg_next.yellow_len    = cfg_wr_data[YLEN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_change  <= RST_FIRST_CHANGE;
            cfg_reg.second_change <= RST_SECOND_CHANGE;
            cfg_reg.third_change  <= RST_THIRD_CHANGE;
            cfg_reg.cycle_len     <= RST_CYCLE;
            cfg_reg.yellow_len    <= RST_MAN_YELLOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tlseq_step.sv
// One-second step of the sequence: next state and the result shown for the tick.
`timescale 1ns / 1ps

module tlseq_step (
    input  tlseq_pkg::cfg_t        cfg,
    input  tlseq_pkg::seq_state_t  cur,
    input  logic                   auto_sw,
    input  logic                   dir_sw,
    output tlseq_pkg::seq_state_t  nxt,
    output tlseq_pkg::result_t     res
);
    import tlseq_pkg::*;

    logic [COUNT_W-1:0] cyc_len;
    logic [YLEN_W-1:0]  yel_len;
    seq_state_t         tick;
    logic [13:0]        tens_prod;
    logic [3:0]         tens;
    logic [COUNT_W-1:0] tens_x10;
    logic [COUNT_W-1:0] ones_full;

    // Out-of-range lengths fold into their legal range
    always_comb begin
        if (cfg.cycle_len == '0) begin
            cyc_len = 7'd1;
        end else if (cfg.cycle_len > CYCLE_MAX) begin
            cyc_len = CYCLE_MAX;
        end else begin
            cyc_len = cfg.cycle_len;
        end
        if (cfg.yellow_len == '0) begin
            yel_len = 4'd1;
        end else if (cfg.yellow_len > YELLOW_MAX) begin
            yel_len = YELLOW_MAX;
        end else begin
            yel_len = cfg.yellow_len;
        end
    end

    // Advance the count and mode for this tick
    always_comb begin
        tick = cur;
        if (auto_sw) begin
            if (cur.mode != MODE_AUTO || cur.count == '0 || cur.count >= cyc_len) begin
                tick.mode  = MODE_AUTO;
                tick.count = 7'd1;
                tick.west  = LAMP_YELLOW;
                tick.south = LAMP_RED;
            end else begin
                tick.count = cur.count + 7'd1;
            end
        end else begin
            if (cur.mode == MODE_IDLE || cur.mode == MODE_AUTO || dir_sw != cur.dir) begin
                // (re)start manual yellow for the chosen road
                tick.mode  = MODE_MAN_YELLOW;
                tick.count = 7'd1;
                tick.dir   = dir_sw;
                tick.west  = dir_sw ? LAMP_YELLOW : LAMP_RED;
                tick.south = dir_sw ? LAMP_RED : LAMP_YELLOW;
            end else if (cur.mode == MODE_MAN_YELLOW) begin
                if (cur.count >= {3'd0, yel_len}) begin
                    tick.mode  = MODE_MAN_GREEN;
                    tick.count = '0;
                    if (cur.dir) begin
                        tick.west = LAMP_GREEN;
                    end else begin
                        tick.south = LAMP_GREEN;
                    end
                end else begin
                    tick.count = cur.count + 7'd1;
                end
            end
        end
    end

    // Thresholds act after the tick is shown; later matches win
    always_comb begin
        nxt = tick;
        if (auto_sw) begin
            if (tick.count == cfg.first_change) begin
                nxt.west = LAMP_GREEN;
            end
            if (tick.count == cfg.second_change) begin
                nxt.west  = LAMP_RED;
                nxt.south = LAMP_YELLOW;
            end
            if (tick.count == cfg.third_change) begin
                nxt.south = LAMP_GREEN;
            end
        end
    end

    // BCD split: count stays below 100, so x*103 >> 10 gives the tens digit
    assign tens_prod = {7'd0, tick.count} * 14'd103;
    assign tens      = tens_prod[13:10];
    assign tens_x10  = {tens, 3'd0} + {2'd0, tens, 1'b0};
    assign ones_full = tick.count - tens_x10;

    assign res.south = tick.south;
    assign res.west  = tick.west;
    assign res.tens  = tens;
    assign res.ones  = ones_full[3:0];

endmodule
